>>> rtl/pidc_pkg.sv
// Shared types and constants for the PNG IDAT CRC extractor.
package pidc_pkg;

  // One input word after registering
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pidc_in_t;

  // Eight-byte PNG file signature
  localparam logic [7:0] SIG_BYTES [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  // Chunk type "IDAT", big-endian
  localparam logic [31:0] IDAT_TYPE = 32'h4944_4154;

  // Value given when no IDAT CRC was found
  localparam logic [31:0] CRC_NONE = 32'h0000_0000;

  // Value a zero CRC is bumped to
  localparam logic [31:0] CRC_ZERO_BUMP = 32'h0000_0001;

endpackage

>>> rtl/pidc_if.sv
// Valid/ready channel interfaces for the byte input and the CRC output.
interface pidc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pidc_crc_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

>>> rtl/png_idat_crc_extractor_top.sv
// Held bytes are parsed once the result slot is free; any CRC word is offered from then.
// Throughput: one byte per cycle while the result slot is free; parser state is the sole loop.
// Sink back-pressure on a full result slot stalls the input register and thus the byte stream.
// Reset: rst_ni low clears all control state asynchronously; parser restarts at the signature.
// The final byte of each buffer also rearms the parser after its own result.
module png_idat_crc_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pidc_byte_if.sink   in_i,
  pidc_crc_if.source  out_o
);
  import pidc_pkg::*;

  pidc_in_t    in_word;
  pidc_in_t    word;
  logic        word_valid;
  logic        advance;
  logic        slot_free;
  logic        res_valid;
  logic [31:0] res_crc;

  assign in_word.data_byte = in_i.data_byte;
  assign in_word.last_byte = in_i.last_byte;

  // A held word moves into the parser when the result slot can take a word
  assign advance = word_valid && slot_free;

  pidc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_word_i    (in_word),
    .word_valid_o (word_valid),
    .word_o       (word),
    .advance_i    (advance)
  );

  pidc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .word_i      (word),
    .res_valid_o (res_valid),
    .res_crc_o   (res_crc)
  );

  pidc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_crc_i   (res_crc),
    .free_o      (slot_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_crc_o   (out_o.crc_value)
  );

endmodule

>>> rtl/pidc_in_stage.sv
// Input register stage: holds one byte word until the parser takes it.
module pidc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pidc_pkg::pidc_in_t in_word_i,
  output logic              word_valid_o,
  output pidc_pkg::pidc_in_t word_o,
  input  logic              advance_i
);
  import pidc_pkg::*;

  logic     valid_q, valid_d;
  pidc_in_t word_q;
  logic     load;

  // Free when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= in_word_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

>>> rtl/pidc_parser.sv
// Chunk walker: signature check, length/type capture, data skip, CRC capture.
module pidc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pidc_pkg::pidc_in_t word_i,
  output logic               res_valid_o,
  output logic [31:0]        res_crc_o
);
  import pidc_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC,
    PH_WAIT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        answered_q, answered_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] skip_q, skip_d;
  logic [23:0] crc_q, crc_d;
  logic [31:0] crc_full;
  logic        res_valid;
  logic [31:0] res_crc;

  assign crc_full = {crc_q, word_i.data_byte};

  // Next state for one byte
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    answered_d = answered_q;
    len_d      = len_q;
    type_d     = type_q;
    skip_d     = skip_q;
    crc_d      = crc_q;
    res_valid  = 1'b0;
    res_crc    = CRC_NONE;

    if (!answered_q) begin
      case (phase_q)
        PH_SIG: begin
          if (word_i.data_byte != SIG_BYTES[cnt_q]) begin
            phase_d = PH_WAIT;
            cnt_d   = 3'd0;
          end else begin
            cnt_d = cnt_q + 3'd1;
            if (cnt_q == 3'd7) begin
              phase_d = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          len_d = {len_q[23:0], word_i.data_byte};
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            cnt_d   = 3'd0;
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_d = {type_q[23:0], word_i.data_byte};
          cnt_d  = cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            cnt_d   = 3'd0;
            skip_d  = len_q;
            phase_d = (len_q != 32'd0) ? PH_DATA : PH_CRC;
          end
        end
        PH_DATA: begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          crc_d = crc_full[23:0];
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            cnt_d = 3'd0;
            // CRC of the first IDAT chunk is the answer; zero is bumped
            if (type_q == IDAT_TYPE) begin
              res_valid  = 1'b1;
              res_crc    = (crc_full != 32'd0) ? crc_full : CRC_ZERO_BUMP;
              answered_d = 1'b1;
              phase_d    = PH_WAIT;
            end else begin
              phase_d = PH_LEN;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Final byte: report a miss if still unanswered, and rearm
    if (word_i.last_byte) begin
      if (!res_valid && !answered_q) begin
        res_valid = 1'b1;
        res_crc   = CRC_NONE;
      end
      phase_d    = PH_SIG;
      cnt_d      = 3'd0;
      answered_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIG;
      cnt_q      <= 3'd0;
      answered_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      answered_q <= answered_d;
    end
  end

  // Shift registers, no reset: each is refilled before use
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      len_q  <= len_d;
      type_q <= type_d;
      skip_q <= skip_d;
      crc_q  <= crc_d;
    end
  end

  assign res_valid_o = step_i && res_valid;
  assign res_crc_o   = res_crc;

endmodule

>>> rtl/pidc_out_stage.sv
// Result register: holds one CRC word until the sink takes it.
module pidc_out_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_valid_i,
  input  logic [31:0] res_crc_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_crc_o
);

  logic        valid_q, valid_d;
  logic [31:0] crc_q;

  // Slot is free when empty or being drained this cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = res_valid_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      crc_q <= res_crc_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_crc_o   = crc_q;

endmodule

>>> bench/png_idat_crc_extractor_top_tb.sv
// Self-checking testbench for the PNG IDAT CRC extractor: PNG byte streams in, CRC words checked.
module png_idat_crc_extractor_top_tb;
  import pidc_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned REPORT_MAX   = 10;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    PH_SIGNATURE, PH_LENGTH, PH_TYPE, PH_SKIP, PH_CRC, PH_IDLE
  } parse_phase_e;

  // Predicts the CRC word of each buffer and checks the words that come out
  class crc_scoreboard;
    parse_phase_e phase;
    logic [3:0]   field_cnt;
    logic [31:0]  length_sr;
    logic [31:0]  type_sr;
    logic [31:0]  skip_left;
    logic [31:0]  crc_sr;
    bit           answered;
    logic [31:0]  crc_expected_q[$];
    int unsigned  mismatches;
    int unsigned  parsed_bytes;
    int unsigned  crc_found;
    int unsigned  crc_none;

    function new();
      rearm();
    endfunction

    function void rearm();
      phase     = PH_SIGNATURE;
      field_cnt = '0;
      length_sr = '0;
      type_sr   = '0;
      skip_left = '0;
      crc_sr    = '0;
      answered  = 1'b0;
    endfunction

    function int unsigned pending();
      return crc_expected_q.size();
    endfunction

    // Queue one expected CRC word at the tail
    function void expect_word(logic [31:0] w);
      crc_expected_q = {crc_expected_q, w};
    endfunction

    // Note one accepted input word and queue any CRC word it causes
    function void note_byte(logic [7:0] b, logic fin);
      bit was_answered;
      bit produced;
      was_answered = answered;
      produced     = 1'b0;
      if (!was_answered) begin
        parsed_bytes++;
        case (phase)
          PH_SIGNATURE: begin
            if (b != SIG_BYTES[field_cnt[2:0]]) begin
              phase     = PH_IDLE;
              field_cnt = '0;
            end else begin
              field_cnt++;
              if (field_cnt >= 4'd8) begin
                field_cnt = '0;
                phase     = PH_LENGTH;
              end
            end
          end
          PH_LENGTH: begin
            length_sr = {length_sr[23:0], b};
            field_cnt++;
            if (field_cnt >= 4'd4) begin
              field_cnt = '0;
              phase     = PH_TYPE;
            end
          end
          PH_TYPE: begin
            type_sr = {type_sr[23:0], b};
            field_cnt++;
            if (field_cnt >= 4'd4) begin
              field_cnt = '0;
              skip_left = length_sr;
              phase     = (skip_left != 0) ? PH_SKIP : PH_CRC;
            end
          end
          PH_SKIP: begin
            skip_left = skip_left - 1;
            if (skip_left == 0) phase = PH_CRC;
          end
          PH_CRC: begin
            crc_sr = {crc_sr[23:0], b};
            field_cnt++;
            if (field_cnt >= 4'd4) begin
              field_cnt = '0;
              if (type_sr == IDAT_TYPE) begin
                expect_word((crc_sr != 0) ? crc_sr : CRC_ZERO_BUMP);
                produced = 1'b1;
                answered = 1'b1;
                phase    = PH_IDLE;
              end else begin
                phase = PH_LENGTH;
              end
            end
          end
          default: ;
        endcase
      end
      // final byte: report "none found" if still unanswered, then start afresh
      if (fin) begin
        if (!produced && !was_answered) expect_word(CRC_NONE);
        rearm();
      end
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch: %s: crc_value expected %08h, got %08h", what, want, got);
    endfunction

    // Compare one accepted CRC word with the oldest expectation
    function void check_crc(logic [31:0] got);
      logic [31:0] want;
      if (crc_expected_q.size() == 0) begin
        flag("unexpected word", 'x, got);
      end else begin
        want = crc_expected_q.pop_front();
        if (got !== want) flag("wrong word", want, got);
        else if (want == CRC_NONE) crc_none++;
        else crc_found++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pidc_byte_if byte_bus ();
  pidc_crc_if  crc_bus ();

  png_idat_crc_extractor_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_bus),
    .out_o  (crc_bus)
  );

  crc_scoreboard sb = new();

  logic [7:0]  file_q[$];
  bit          no_gaps;
  int unsigned bytes_sent;
  int unsigned buffers_sent;
  int unsigned idle_cycles;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Buffer building
  function automatic void add_byte(logic [7:0] b);
    file_q = {file_q, b};
  endfunction

  function automatic void push_u32(logic [31:0] v);
    add_byte(v[31:24]);
    add_byte(v[23:16]);
    add_byte(v[15:8]);
    add_byte(v[7:0]);
  endfunction

  function automatic void push_signature();
    for (int i = 0; i < 8; i++) add_byte(SIG_BYTES[i]);
  endfunction

  function automatic void push_chunk(logic [31:0] len, logic [31:0] kind, logic [31:0] crc);
    push_u32(len);
    push_u32(kind);
    for (int i = 0; i < len; i++) add_byte(8'($urandom));
    push_u32(crc);
  endfunction

  function automatic logic [31:0] other_type();
    logic [31:0] t;
    if ($urandom_range(0, 1)) begin
      t = IDAT_TYPE ^ (32'h1 << $urandom_range(0, 31));
    end else begin
      t = $urandom;
      if (t == IDAT_TYPE) t = ~t;
    end
    return t;
  endfunction

  // Well-formed file: up to two other chunks, usually an IDAT, maybe trailing bytes
  function automatic void build_good_file();
    logic [31:0] crc;
    int          n_pre;
    file_q.delete();
    push_signature();
    n_pre = $urandom_range(0, 2);
    for (int i = 0; i < n_pre; i++)
      push_chunk($urandom_range(0, 6), other_type(), $urandom);
    if ($urandom_range(0, 9) != 0) begin
      crc = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
      push_chunk(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12), IDAT_TYPE, crc);
      if ($urandom_range(0, 6) == 0)
        push_chunk($urandom_range(0, 3), IDAT_TYPE, $urandom);
      else
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    end
  endfunction

  // Drive one word; returns at the falling edge after it was taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    byte_bus.last_byte <= fin;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    sb.note_byte(b, fin);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < file_q.size(); i++)
      send_byte(file_q[i], i == file_q.size() - 1);
    buffers_sent++;
  endtask

  // Hold the sender off until every expected word has come out
  task automatic drain_results();
    byte_bus.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // Result sink: ready with random stalls, in randomly chosen calm and busy stretches
  int unsigned stall_left;
  int unsigned mode_left;
  bit          calm;
  always @(negedge clk_i) begin
    int r;
    if (mode_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      mode_left = $urandom_range(50, 200);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      crc_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      crc_bus.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (!calm) begin
        if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 29) stall_left = $urandom_range(8, 40);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && crc_bus.valid && crc_bus.ready) sb.check_crc(crc_bus.crc_value);
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_bus.valid && byte_bus.ready) || (crc_bus.valid && crc_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d CRC words outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int          kind;
    int          cut;
    int unsigned rand_files;
    byte_bus.valid     = 1'b0;
    byte_bus.data_byte = '0;
    byte_bus.last_byte = 1'b0;
    rst_ni             = 1'b0;
    no_gaps            = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: bad signature on a one-byte buffer, all-zero and all-one bytes
    file_q = '{8'h00};
    send_file();
    file_q = '{8'hFF};
    send_file();
    // Smallest file: empty IDAT whose zero CRC ends the buffer
    file_q.delete();
    push_signature();
    push_chunk(32'h0, IDAT_TYPE, 32'h0);
    send_file();
    // Buffer ending inside the signature
    file_q = '{SIG_BYTES[0], SIG_BYTES[1]};
    send_file();

    // Random files, mostly well formed
    rand_files = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        build_good_file();
      end else if (kind < 70) begin
        // truncated anywhere
        build_good_file();
        cut    = $urandom_range(1, file_q.size() - 1);
        file_q = file_q[0:cut-1];
      end else if (kind < 80) begin
        // one signature byte spoilt
        build_good_file();
        cut = $urandom_range(0, 7);
        file_q[cut] = file_q[cut] ^ 8'($urandom_range(1, 255));
      end else if (kind < 90) begin
        // huge length, buffer ends while skipping
        file_q.delete();
        push_signature();
        case ($urandom_range(0, 2))
          0:       push_u32(32'hFFFF_FFFF);
          1:       push_u32(32'h8000_0000 | $urandom);
          default: push_u32($urandom | 32'h0001_0000);
        endcase
        push_u32($urandom_range(0, 1) ? IDAT_TYPE : other_type());
        repeat ($urandom_range(0, 20)) add_byte(8'($urandom));
      end else begin
        // noise
        file_q.delete();
        if ($urandom_range(0, 1)) add_byte(SIG_BYTES[0]);
        repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
      end
      send_file();
      rand_files++;
      if (rand_files == 15 || $urandom_range(0, 19) == 0) drain_results();
    end

    // Wait for the last words, then watch for stray output
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes in %0d buffers (%0d parsed, the rest ignored after a result).",
             bytes_sent, buffers_sent, sb.parsed_bytes);
    $display("Checked %0d IDAT CRC words and %0d not-found words; %0d mismatches.",
             sb.crc_found, sb.crc_none, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
